// ===== rtl/core/ptme_pkg.sv =====
// Package for the two-level page table map engine.
// Holds the command kinds, the command word between front and back, and the
// fixed index and stream widths; no dependencies.
`default_nettype none

package ptme_pkg;

  localparam int DIR_IDX_W     = 10;
  localparam int TAB_IDX_W     = 10;
  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int ENTRY_W       = 32;
  localparam logic [ENTRY_W-1:0] FRAME_MASK = 32'hFFFF_F000;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_MAP    = 2'd0,
    OP_UNMAP  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t               kind;
    logic [DIR_IDX_W-1:0]   dir_idx;
    logic [TAB_IDX_W-1:0]   tab_idx;
    logic [ENTRY_W-1:0]     entry;
  } cmd_t;

  // back end to front end
  typedef struct packed {
    logic init_busy;
    logic pop;
  } be_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/page_table_map_engine_unit.sv =====
// Two-level page table map engine: map, unmap and lookup on a 1024-entry directory
// of tables drawn from a pool of TABLE_POOL 1024-entry tables. Lookup, unmap and
// map into a linked table pass S_IDLE, S_DIR, S_TRD or S_WR, and S_DONE; lookup
// or unmap of an empty slot and map with a dry pool skip the table state, and an
// unknown opcode goes directly to S_DONE; a map that links a new table clears it in
// S_CLR, one entry a cycle. After reset S_INIT clears the directory, in_tready low.
`default_nettype none

module page_table_map_engine_unit #(
  parameter int TABLE_POOL = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // opcode[1:0], virt_addr[33:2], phys_addr[65:34], entry_flags[77:66]
  input  wire logic [ptme_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // found[0], mapped_addr[32:1], status[33]
  output logic [ptme_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  logic               q_valid;
  ptme_pkg::cmd_t     q_cmd;
  ptme_pkg::be_ctrl_t be_ctrl;

  ptme_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .be_ctrl   (be_ctrl),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd)
  );

  ptme_back #(.TABLE_POOL(TABLE_POOL)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .be_ctrl    (be_ctrl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ptme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the directory and the table store; no dependencies.
`default_nettype none

module ptme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptme_front.sv =====
// Front end: accepts input words, classifies them into commands and holds
// them in a two-entry queue for the back end. Depends on ptme_pkg.
`default_nettype none

module ptme_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [ptme_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire ptme_pkg::be_ctrl_t             be_ctrl,
  output logic                                q_valid,
  output ptme_pkg::cmd_t                      q_cmd
);

  ptme_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push;
  logic           pop;
  ptme_pkg::cmd_t cmd_in;

  logic [1:0]  f_opcode;
  logic [31:0] f_virt;
  logic [31:0] f_phys;
  logic [11:0] f_flags;

  assign f_opcode = in_tdata[1:0];
  assign f_virt   = in_tdata[33:2];
  assign f_phys   = in_tdata[65:34];
  assign f_flags  = in_tdata[77:66];

  always_comb begin
    cmd_in.dir_idx = f_virt[31:22];
    cmd_in.tab_idx = f_virt[21:12];
    unique case (f_opcode)
      ptme_pkg::OP_MAP: begin
        cmd_in.kind  = ptme_pkg::OP_MAP;
        cmd_in.entry = (f_phys & ptme_pkg::FRAME_MASK) | {20'd0, f_flags};
      end
      ptme_pkg::OP_UNMAP: begin
        cmd_in.kind  = ptme_pkg::OP_UNMAP;
        cmd_in.entry = '0;
      end
      ptme_pkg::OP_LOOKUP: begin
        cmd_in.kind  = ptme_pkg::OP_LOOKUP;
        cmd_in.entry = '0;
      end
      default: begin
        cmd_in.kind  = ptme_pkg::OP_NONE;
        cmd_in.entry = '0;
      end
    endcase
  end

  assign in_tready = (count_r != 2'd2) && !be_ctrl.init_busy;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_cmd     = slot_r[rd_ptr_r];
  assign pop       = be_ctrl.pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptme_back.sv =====
// Back end: walks the directory and table store for each queued command,
// allocates and clears tables, and drives the result register.
// Depends on ptme_pkg and ptme_ram.
`default_nettype none

module ptme_back #(
  parameter int TABLE_POOL = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire ptme_pkg::cmd_t                   q_cmd,
  output ptme_pkg::be_ctrl_t                    be_ctrl,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [ptme_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int DW     = $clog2(TABLE_POOL + 1);
  localparam int SLOT_W = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int TAB_DEPTH = TABLE_POOL * ptme_pkg::TABLE_ENTRIES;
  localparam int TAB_AW = $clog2(TAB_DEPTH);
  localparam int CNT_W  = ptme_pkg::TAB_IDX_W;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DIR, S_CLR, S_WR, S_TRD, S_DONE
  } state_t;

  state_t                          state_r;
  ptme_pkg::cmd_t                  cmd_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [DW-1:0]                   next_free_r;
  logic [SLOT_W-1:0]               slot_r;
  logic                            res_found_r;
  logic [ptme_pkg::ENTRY_W-1:0]    res_mapped_r;
  logic                            res_status_r;
  logic                            out_valid_r;
  logic                            out_found_r;
  logic [ptme_pkg::ENTRY_W-1:0]    out_mapped_r;
  logic                            out_status_r;

  logic                            dir_we;
  logic [ptme_pkg::DIR_IDX_W-1:0]  dir_waddr;
  logic [DW-1:0]                   dir_wdata;
  logic [DW-1:0]                   dir_rdata;
  logic                            tab_we;
  logic [TAB_AW-1:0]               tab_waddr;
  logic [ptme_pkg::ENTRY_W-1:0]    tab_wdata;
  logic [TAB_AW-1:0]               tab_raddr;
  logic [ptme_pkg::ENTRY_W-1:0]    tab_rdata;
  logic [SLOT_W-1:0]               link_slot;
  logic                            pool_empty;
  logic                            out_free;

  assign link_slot  = SLOT_W'(dir_rdata - DW'(1));
  assign pool_empty = (next_free_r >= DW'(TABLE_POOL));
  assign out_free   = !out_valid_r || out_tready;

  assign be_ctrl.init_busy = (state_r == S_INIT);
  assign be_ctrl.pop       = (state_r == S_IDLE) && q_valid;

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = cmd_r.dir_idx;
    dir_wdata = next_free_r + DW'(1);
    tab_we    = 1'b0;
    tab_waddr = TAB_AW'({slot_r, cmd_r.tab_idx});
    tab_wdata = cmd_r.entry;
    tab_raddr = TAB_AW'({link_slot, cmd_r.tab_idx});
    unique case (state_r)
      S_INIT: begin
        dir_we    = 1'b1;
        dir_waddr = cnt_r;
        dir_wdata = '0;
      end
      S_DIR: begin
        // link a fresh table from the pool
        dir_we = (cmd_r.kind == ptme_pkg::OP_MAP) && (dir_rdata == '0) && !pool_empty;
      end
      S_CLR: begin
        tab_we    = 1'b1;
        tab_waddr = TAB_AW'({slot_r, cnt_r});
        tab_wdata = '0;
      end
      S_WR: begin
        tab_we = 1'b1;
      end
      default: ;
    endcase
  end

  ptme_ram #(.WIDTH(DW), .DEPTH(ptme_pkg::DIR_ENTRIES)) u_dir_ram (
    .clk     (clk),
    .we      (dir_we),
    .waddr   (dir_waddr),
    .wdata   (dir_wdata),
    .raddr   (q_cmd.dir_idx),
    .rdata_r (dir_rdata)
  );

  ptme_ram #(.WIDTH(ptme_pkg::ENTRY_W), .DEPTH(TAB_DEPTH)) u_tab_ram (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (tab_waddr),
    .wdata   (tab_wdata),
    .raddr   (tab_raddr),
    .rdata_r (tab_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r        <= q_cmd;
            res_found_r  <= 1'b0;
            res_mapped_r <= '0;
            res_status_r <= 1'b0;
            state_r      <= (q_cmd.kind == ptme_pkg::OP_NONE) ? S_DONE : S_DIR;
          end
        end
        S_DIR: begin
          unique case (cmd_r.kind)
            ptme_pkg::OP_MAP: begin
              priority if (dir_rdata != '0) begin
                slot_r  <= link_slot;
                state_r <= S_WR;
              end else if (pool_empty) begin
                res_status_r <= 1'b1;
                state_r      <= S_DONE;
              end else begin
                slot_r      <= SLOT_W'(next_free_r);
                next_free_r <= next_free_r + DW'(1);
                cnt_r       <= '0;
                state_r     <= S_CLR;
              end
            end
            ptme_pkg::OP_UNMAP: begin
              slot_r  <= link_slot;
              state_r <= (dir_rdata != '0) ? S_WR : S_DONE;
            end
            default: begin
              state_r <= (dir_rdata != '0) ? S_TRD : S_DONE;
            end
          endcase
        end
        S_CLR: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == '1) state_r <= S_WR;
        end
        S_WR: begin
          state_r <= S_DONE;
        end
        S_TRD: begin
          res_found_r  <= (tab_rdata != '0);
          res_mapped_r <= tab_rdata & ptme_pkg::FRAME_MASK;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_found_r  <= res_found_r;
            out_mapped_r <= res_mapped_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_mapped_r, out_found_r};

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for page_table_map_engine_unit: directed words, then three
// random phases, two idling on either side, checked against a local page table model.
// Depends on ptme_pkg and the page_table_map_engine_unit RTL.
`timescale 1ns / 100ps

module tb;
  import ptme_pkg::*;

  localparam int POOL_TABLES = 64;
  localparam int STALL_LIMIT = 6000;
  localparam int TAIL_CYCLES = 32;
  localparam int RAND_WORDS  = 1400;

  typedef struct packed {
    op_kind_t    op;
    logic [31:0] va;
    logic [31:0] pa;
    logic [11:0] flags;
  } page_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] mapped;
    logic        status;
  } page_reply_t;

  typedef struct {
    page_req_t   req;
    bit          fixed;
    page_reply_t reply;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // model state
  int unsigned dir_link [0:DIR_ENTRIES-1];
  logic [31:0] tbl_words [0:POOL_TABLES*TABLE_ENTRIES-1];
  int unsigned next_slot;

  page_reply_t pending_replies[$];
  script_row_t script[$];
  logic [9:0]  dir_pool [0:95];
  logic [9:0]  tab_pool [0:15];

  int          err_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  page_reply_t got_reply;
  page_reply_t want_reply;

  always #6 clk = ~clk;

  page_table_map_engine_unit #(
    .TABLE_POOL(POOL_TABLES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic page_reply_t apply_page_op(input page_req_t r);
    page_reply_t rep;
    int unsigned d;
    int unsigned t;
    int unsigned link;
    logic [31:0] e;
    rep  = '0;
    d    = r.va[31:22];
    t    = r.va[21:12];
    link = dir_link[d];
    case (r.op)
      OP_MAP: begin
        if (link == 0) begin
          if (next_slot >= POOL_TABLES) begin
            rep.status = 1'b1;
          end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tbl_words[next_slot*TABLE_ENTRIES+i] = '0;
            next_slot++;
            dir_link[d] = next_slot;
            link = next_slot;
          end
        end
        if (link != 0) tbl_words[(link-1)*TABLE_ENTRIES+t] = (r.pa & FRAME_MASK) | {20'd0, r.flags};
      end
      OP_UNMAP: begin
        if (link != 0) tbl_words[(link-1)*TABLE_ENTRIES+t] = '0;
      end
      OP_LOOKUP: begin
        if (link != 0) begin
          e = tbl_words[(link-1)*TABLE_ENTRIES+t];
          if (e != 0) begin
            rep.found  = 1'b1;
            rep.mapped = e & FRAME_MASK;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic page_req_t random_req();
    page_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.op = OP_MAP;
    else if (pick < 50) r.op = OP_UNMAP;
    else if (pick < 95) r.op = OP_LOOKUP;
    else r.op = OP_NONE;
    // mostly a small working set of tables so lookups hit and the pool runs dry
    if ($urandom_range(0, 9) == 0) r.va = $urandom;
    else r.va = {dir_pool[$urandom_range(0, 95)], tab_pool[$urandom_range(0, 15)], 12'($urandom)};
    r.pa    = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom);
    r.flags = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
    return r;
  endfunction

  task automatic add_row(input op_kind_t op, input logic [31:0] va, input logic [31:0] pa,
                         input logic [11:0] flags, input bit fixed, input logic found,
                         input logic [31:0] mapped, input logic status);
    script_row_t row;
    row.req   = '{op: op, va: va, pa: pa, flags: flags};
    row.fixed = fixed;
    row.reply = '{found: found, mapped: mapped, status: status};
    script.push_back(row);
  endtask

  // Offer one word, idling first at the current rate; record its reply on accept.
  task automatic send_word(input page_req_t r, input bit fixed, input page_reply_t fixed_reply);
    page_reply_t rep;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, r.flags, r.pa, r.va, r.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rep = apply_page_op(r);
    pending_replies.push_back(fixed ? fixed_reply : rep);
  endtask

  // Hold the sender until every outstanding reply is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_reply = '{found: out_tdata[0], mapped: out_tdata[32:1], status: out_tdata[33]};
      if (pending_replies.size() == 0) begin
        $error("result word with no reply expected: %h", out_tdata);
        err_cnt++;
      end else begin
        want_reply = pending_replies.pop_front();
        if (got_reply.found !== want_reply.found) begin
          $error("found: expected %0d, got %0d", want_reply.found, got_reply.found);
          err_cnt++;
        end
        if (got_reply.mapped !== want_reply.mapped) begin
          $error("mapped_addr: expected %h, got %h", want_reply.mapped, got_reply.mapped);
          err_cnt++;
        end
        if (got_reply.status !== want_reply.status) begin
          $error("status: expected %0d, got %0d", want_reply.status, got_reply.status);
          err_cnt++;
        end
      end
    end
  end

  // Stop on a long stretch with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("page_table_map_engine_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < DIR_ENTRIES; i++) dir_link[i] = 0;
    for (int i = 0; i < POOL_TABLES*TABLE_ENTRIES; i++) tbl_words[i] = '0;
    next_slot = 0;
    for (int i = 0; i < 96; i++) dir_pool[i] = 10'($urandom_range(0, 1023));
    for (int i = 0; i < 16; i++) tab_pool[i] = 10'($urandom_range(0, 1023));

    // empty tables, then extremes, flags-only and zero entries
    add_row(OP_LOOKUP, 32'h0000_0000, 32'h0,          12'h000, 1, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  12'hFFF, 1, 0, 32'h0,         0);
    add_row(OP_UNMAP,  32'h0000_0000, 32'h0,          12'h000, 1, 0, 32'h0,         0);
    add_row(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF,  12'hFFF, 1, 0, 32'h0,         0);
    add_row(OP_MAP,    32'h0000_0000, 32'hFFFF_FFFF,  12'hFFF, 1, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'h0000_0000, 32'h0,          12'h000, 1, 1, 32'hFFFF_F000, 0);
    add_row(OP_MAP,    32'hFFFF_FFFF, 32'h0000_0FFF,  12'h000, 1, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0,          12'h000, 1, 0, 32'h0,         0);
    add_row(OP_MAP,    32'h0000_1000, 32'h0,          12'h001, 1, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'h0000_1000, 32'h0,          12'h000, 1, 1, 32'h0,         0);
    add_row(OP_UNMAP,  32'h0000_0000, 32'h0,          12'h000, 1, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'h0000_0000, 32'h0,          12'h000, 1, 0, 32'h0,         0);
    add_row(OP_MAP,    32'h0040_0000, 32'h1234_5678,  12'hABC, 0, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'h0040_0FFF, 32'h0,          12'h000, 0, 0, 32'h0,         0);
    add_row(OP_MAP,    32'h007F_F000, 32'hFFFF_F000,  12'h000, 0, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'h007F_FABC, 32'h0,          12'h000, 0, 0, 32'h0,         0);
    add_row(OP_MAP,    32'h0040_0000, 32'hA5A5_A5A5,  12'h5A5, 0, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'h0040_0000, 32'h0,          12'h000, 0, 0, 32'h0,         0);
    add_row(OP_NONE,   32'h0000_0000, 32'h0,          12'h000, 1, 0, 32'h0,         0);
    add_row(OP_UNMAP,  32'hFFFF_FFFF, 32'h0,          12'h000, 1, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'h0000_1234, 32'h0,          12'h000, 0, 0, 32'h0,         0);
    add_row(OP_UNMAP,  32'h0040_0000, 32'h0,          12'h000, 0, 0, 32'h0,         0);
    add_row(OP_LOOKUP, 32'h0040_0000, 32'h0,          12'h000, 0, 0, 32'h0,         0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_word(script[i].req, script[i].fixed, script[i].reply);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 28 : 0;
      for (int n = 0; n < RAND_WORDS / 3; n++) send_word(random_req(), 1'b0, '0);
      drain();
    end

    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_replies.size() == 0) begin
      $display("page_table_map_engine_unit verification clean");
    end else begin
      $display("page_table_map_engine_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ptme_pkg.sv
rtl/core/ptme_ram.sv
rtl/core/ptme_front.sv
rtl/core/ptme_back.sv
rtl/core/page_table_map_engine_unit.sv
tb/tb.sv
